// ===== rtl/hrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants for the HID report framer: item codes, the
// command record passed from front to back, and report framing constants.
// ----------------------------------------------------------------------------
package hrf_pkg;

  // item codes on in_func
  localparam logic [1:0] FUNC_BEGIN   = 2'd0;
  localparam logic [1:0] FUNC_PAYLOAD = 2'd1;
  localparam logic [1:0] FUNC_FINISH  = 2'd2;
  localparam logic [1:0] FUNC_POP     = 2'd3;

  // report framing
  localparam int unsigned REPORT_BYTES     = 64;
  localparam int unsigned OFFS_W           = 6;
  localparam logic [OFFS_W-1:0] OFFS_LAST  = OFFS_W'(REPORT_BYTES - 1);
  localparam logic [7:0]  REPORT_MARK      = 8'h3F;  // '?'
  localparam logic [7:0]  HEADER_MARK      = 8'h23;  // '#'
  localparam logic [7:0]  PAD_BYTE         = 8'h00;

  // ring size default
  localparam int unsigned REPORT_SLOTS_DEF = 16;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = 2;

  // one command: up to eight bytes to append, byte 0 in bits 7:0
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  last_idx;
    logic [63:0] bytes;
  } cmd_t;

endpackage : hrf_pkg
`default_nettype wire

// ===== rtl/hid_report_framer_ring.sv =====
`default_nettype none
// An item can leave the input queue at the earliest in the cycle after its transfer. Begin
// writes eight header bytes and payload one byte, each after the '?' marker if it opens a
// report; finish pads an open report; pop streams 64 bytes at one byte per cycle while
// out_stall is low, or gives one empty result. Popped bytes pass the registered read stage and
// the output register; a four-entry command queue lets inputs continue while a report streams out.
// Reset: synchronous active-low rst_n clears slot pointers, offsets and queues; ring contents stay.
// ----------------------------------------------------------------------------
// hid_report_framer_ring
// Frames outgoing messages into 64-byte reports held in a ring of report
// slots and streams complete reports out byte by byte.
// ----------------------------------------------------------------------------
module hid_report_framer_ring
  import hrf_pkg::*;
#(
  parameter int unsigned REPORT_SLOTS = REPORT_SLOTS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_msg_id,
  input  wire logic [31:0] in_msg_len,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_report_byte,
  output logic             out_last_of_report,
  output logic             out_empty_res
);

  logic cmd_valid;
  logic cmd_done;
  cmd_t cmd_head;

  // item intake and command queue
  hrf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_msg_id    (in_msg_id),
    .in_msg_len   (in_msg_len),
    .in_data_byte (in_data_byte),
    .cmd_valid    (cmd_valid),
    .cmd_head     (cmd_head),
    .cmd_done     (cmd_done)
  );

  // ring execution and report streaming
  hrf_back #(
    .REPORT_SLOTS (REPORT_SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd_head           (cmd_head),
    .cmd_done           (cmd_done),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_report_byte    (out_report_byte),
    .out_last_of_report (out_last_of_report),
    .out_empty_res      (out_empty_res)
  );

endmodule : hid_report_framer_ring
`default_nettype wire

// ===== rtl/hrf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_front
// Accepts input items, turns each into a command record (header bytes in
// big-endian order, a single payload byte, finish or pop) and holds the
// records in a small queue for the back end.
// ----------------------------------------------------------------------------
module hrf_front
  import hrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_msg_id,
  input  wire logic [31:0] in_msg_len,
  input  wire logic [7:0]  in_data_byte,
  output logic             cmd_valid,
  output cmd_t             cmd_head,
  input  wire logic        cmd_done
);

  cmd_t                  q_mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   count_r, count_nxt;
  cmd_t                  new_cmd;
  logic                  push;
  logic                  pull;

  // classify the incoming item
  always_comb begin
    new_cmd.op       = in_func;
    new_cmd.last_idx = 3'd0;
    new_cmd.bytes    = {56'd0, in_data_byte};
    unique case (in_func)
      FUNC_BEGIN: begin
        new_cmd.last_idx = 3'd7;
        new_cmd.bytes    = {in_msg_len[7:0], in_msg_len[15:8], in_msg_len[23:16],
                            in_msg_len[31:24], in_msg_id[7:0], in_msg_id[15:8],
                            HEADER_MARK, HEADER_MARK};
      end
      FUNC_PAYLOAD, FUNC_FINISH, FUNC_POP: begin
        new_cmd.last_idx = 3'd0;
      end
      default: begin
        new_cmd.last_idx = 3'd0;
      end
    endcase
  end

  // queue handshake
  assign in_stall  = (count_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign pull      = cmd_valid && cmd_done;
  assign cmd_head  = q_mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pull ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pull) begin
      count_nxt = count_r + 1'b1;
    end else if (pull && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule : hrf_front
`default_nettype wire

// ===== rtl/hrf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrf_back
// Executes queued commands against the report ring: appends bytes with the
// '?' marker at each report start, pads open reports, and streams the oldest
// complete report through a registered read stage and an output register, or an empty result.
// ----------------------------------------------------------------------------
module hrf_back
  import hrf_pkg::*;
#(
  parameter int unsigned REPORT_SLOTS = REPORT_SLOTS_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd_head,
  output logic            cmd_done,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_report_byte,
  output logic            out_last_of_report,
  output logic            out_empty_res
);

  localparam int unsigned SLOT_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
  localparam int unsigned ADDR_W = SLOT_W + OFFS_W;
  localparam int unsigned DEPTH  = REPORT_SLOTS * REPORT_BYTES;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(REPORT_SLOTS - 1);

  logic [7:0]        mem [DEPTH];

  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [OFFS_W-1:0] write_offset_r, write_offset_nxt;
  logic [OFFS_W-1:0] pop_cnt_r, pop_cnt_nxt;
  logic [2:0]        byte_idx_r, byte_idx_nxt;

  logic              rd_valid_r, rd_valid_nxt;
  logic              rd_last_r;
  logic [7:0]        mem_q_r;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_empty_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              issue;
  logic [ADDR_W-1:0] raddr;
  logic              free;
  logic              move;
  logic              load_empty;
  logic [SLOT_W-1:0] write_slot_inc;
  logic [SLOT_W-1:0] read_slot_inc;

  // output register handshake
  assign free = !out_valid_r || !out_stall;
  assign move = rd_valid_r && free;

  assign write_slot_inc = (write_slot_r == SLOT_LAST) ? '0 : write_slot_r + 1'b1;
  assign read_slot_inc  = (read_slot_r == SLOT_LAST) ? '0 : read_slot_r + 1'b1;

  // command sequencer
  always_comb begin
    we               = 1'b0;
    waddr            = {write_slot_r, write_offset_r};
    wdata            = cmd_head.bytes[{byte_idx_r, 3'd0} +: 8];
    issue            = 1'b0;
    raddr            = {read_slot_r, pop_cnt_r};
    load_empty       = 1'b0;
    cmd_done         = 1'b0;
    write_slot_nxt   = write_slot_r;
    read_slot_nxt    = read_slot_r;
    write_offset_nxt = write_offset_r;
    pop_cnt_nxt      = pop_cnt_r;
    byte_idx_nxt     = byte_idx_r;
    if (cmd_valid) begin
      unique case (cmd_head.op)
        FUNC_BEGIN, FUNC_PAYLOAD: begin
          we = 1'b1;
          if (write_offset_r == '0) begin
            // new report opens with its marker
            wdata            = REPORT_MARK;
            write_offset_nxt = OFFS_W'(1);
          end else begin
            if (write_offset_r == OFFS_LAST) begin
              write_offset_nxt = '0;
              write_slot_nxt   = write_slot_inc;
            end else begin
              write_offset_nxt = write_offset_r + 1'b1;
            end
            if (byte_idx_r == cmd_head.last_idx) begin
              byte_idx_nxt = '0;
              cmd_done     = 1'b1;
            end else begin
              byte_idx_nxt = byte_idx_r + 1'b1;
            end
          end
        end
        FUNC_FINISH: begin
          if (write_offset_r == '0) begin
            cmd_done = 1'b1;
          end else begin
            we    = 1'b1;
            wdata = PAD_BYTE;
            if (write_offset_r == OFFS_LAST) begin
              write_offset_nxt = '0;
              write_slot_nxt   = write_slot_inc;
              cmd_done         = 1'b1;
            end else begin
              write_offset_nxt = write_offset_r + 1'b1;
            end
          end
        end
        FUNC_POP: begin
          if (pop_cnt_r == '0 && read_slot_r == write_slot_r) begin
            // nothing complete: one empty result once earlier bytes have left
            if (!rd_valid_r && free) begin
              load_empty = 1'b1;
              cmd_done   = 1'b1;
            end
          end else if (!rd_valid_r || move) begin
            issue = 1'b1;
            if (pop_cnt_r == OFFS_LAST) begin
              pop_cnt_nxt   = '0;
              read_slot_nxt = read_slot_inc;
              cmd_done      = 1'b1;
            end else begin
              pop_cnt_nxt = pop_cnt_r + 1'b1;
            end
          end
        end
        default: begin
          cmd_done = 1'b0;
        end
      endcase
    end
  end

  assign rd_valid_nxt  = issue || (rd_valid_r && !move);
  assign out_valid_nxt = move || load_empty || (out_valid_r && out_stall);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r   <= '0;
      read_slot_r    <= '0;
      write_offset_r <= '0;
      pop_cnt_r      <= '0;
      byte_idx_r     <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      write_slot_r   <= write_slot_nxt;
      read_slot_r    <= read_slot_nxt;
      write_offset_r <= write_offset_nxt;
      pop_cnt_r      <= pop_cnt_nxt;
      byte_idx_r     <= byte_idx_nxt;
      rd_valid_r     <= rd_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // report ring with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      mem_q_r   <= mem[raddr];
      rd_last_r <= (pop_cnt_r == OFFS_LAST);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r  <= mem_q_r;
      out_last_r  <= rd_last_r;
      out_empty_r <= 1'b0;
    end else if (load_empty) begin
      out_byte_r  <= 8'd0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_byte    = out_byte_r;
  assign out_last_of_report = out_last_r;
  assign out_empty_res      = out_empty_r;

endmodule : hrf_back
`default_nettype wire
